// File: sv/tpbf_pkg.sv
// Package for the temporal pixel blend filter.
// Holds sizes, codes, and the types shared by the front, queue and back modules.
package tpbf_pkg;

  localparam int FRAME_BYTES = 16384;
  localparam int MAX_FRAMES  = 10;
  localparam int RING_SLOTS  = MAX_FRAMES - 1;

  localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int N_W    = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int SUM_W  = $clog2(MAX_FRAMES * 255 + 1);
  localparam int STEP_W = $clog2(((MAX_FRAMES > SUM_W) ? MAX_FRAMES : SUM_W) + 1);

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QLVL_W  = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int FLEN_W     = 4;
  localparam int MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN   = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_MIN    = 2'd3
  } blend_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH   = 2'd0,
    REG_BLEND_MODE     = 2'd1,
    REG_FILTER_ENABLED = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [FLEN_W-1:0] frame_length;
    blend_mode_e       mode;
    logic              enabled;
  } cfg_t;

  // One classified byte: the current byte in lane 0, past frames after it,
  // unused lanes padded with 255 so they sort to the top.
  typedef struct packed {
    logic [MAX_FRAMES-1:0][7:0] vals;
    logic [N_W-1:0]             count;
    blend_mode_e                mode;
    logic                       bypass;
    logic                       last;
  } blend_entry_t;

endpackage

// File: sv/tpbf_pixel_if.sv
// Input channel of the temporal pixel blend filter: one pixel byte per beat.
// Depends on nothing.
interface tpbf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       frame_end;

  modport source (output valid, output pixel_byte, output frame_end, input ready);
  modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

// File: sv/tpbf_blend_if.sv
// Output channel of the temporal pixel blend filter: one blended byte per beat.
// Depends on nothing.
interface tpbf_blend_if;
  logic       valid;
  logic       ready;
  logic [7:0] blended_byte;
  logic       frame_end_out;

  modport source (output valid, output blended_byte, output frame_end_out, input ready);
  modport sink   (input valid, input blended_byte, input frame_end_out, output ready);
endinterface

// File: sv/tpbf_cfg_if.sv
// Configuration write channel of the temporal pixel blend filter.
// Depends on tpbf_pkg for the index and data widths.
interface tpbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpbf_pkg::CFG_IDX_W-1:0]  index;
  logic [tpbf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/tpbf_ram.sv
// Generic single-port RAM with registered, read-first data output.
// Depends on nothing.
module tpbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tpbf_front.sv
// Front of the temporal pixel blend filter: accepts bytes, tracks frame state,
// reads and writes the banked history and classifies each byte. Uses tpbf_pkg, tpbf_ram.
module tpbf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tpbf_pixel_if.sink                 pix_i,
  input  tpbf_pkg::cfg_t             cfg_i,
  input  logic [tpbf_pkg::QLVL_W-1:0] q_level_i,
  output logic                       push_o,
  output tpbf_pkg::blend_entry_t     entry_o
);

  logic [tpbf_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [tpbf_pkg::N_W-1:0]    count_q, count_d;
  logic [tpbf_pkg::SLOT_W-1:0] newest_q, newest_d;

  logic                          s1_valid_q;
  logic [7:0]                    s1_px_q;
  logic                          s1_last_q;
  logic [tpbf_pkg::N_W-1:0]      s1_past_q;
  logic [tpbf_pkg::SLOT_W-1:0]   s1_newest_q;
  logic                          s1_bypass_q;
  tpbf_pkg::blend_mode_e         s1_mode_q;

  logic                          accept;
  logic                          in_range;
  logic [tpbf_pkg::N_W-1:0]      len;
  logic [tpbf_pkg::N_W-1:0]      past;
  logic [tpbf_pkg::N_W-1:0]      next_count;
  logic [tpbf_pkg::SLOT_W-1:0]   write_slot;
  logic [tpbf_pkg::QLVL_W:0]     occupancy;
  logic [7:0]                    bank_rdata [tpbf_pkg::RING_SLOTS];

  // Hold off while the queue plus the byte in the read stage would fill it.
  assign occupancy   = {1'b0, q_level_i} + (tpbf_pkg::QLVL_W + 1)'(s1_valid_q);
  assign pix_i.ready = occupancy < (tpbf_pkg::QLVL_W + 1)'(tpbf_pkg::Q_DEPTH);
  assign accept      = pix_i.valid && pix_i.ready;
  assign in_range    = pos_q < tpbf_pkg::POS_W'(tpbf_pkg::FRAME_BYTES);

  always_comb begin
    if (cfg_i.frame_length == '0) begin
      len = tpbf_pkg::N_W'(1);
    end else if (int'(cfg_i.frame_length) > tpbf_pkg::MAX_FRAMES) begin
      len = tpbf_pkg::N_W'(tpbf_pkg::MAX_FRAMES);
    end else begin
      len = tpbf_pkg::N_W'(cfg_i.frame_length);
    end
    past = (count_q > len - 1'b1) ? len - 1'b1 : count_q;
    next_count = past + 1'b1;
    if (int'(next_count) > tpbf_pkg::RING_SLOTS) begin
      next_count = tpbf_pkg::N_W'(tpbf_pkg::RING_SLOTS);
    end
    write_slot = (newest_q == tpbf_pkg::SLOT_W'(tpbf_pkg::RING_SLOTS - 1)) ?
                 '0 : newest_q + 1'b1;
  end

  for (genvar b = 0; b < tpbf_pkg::RING_SLOTS; b++) begin : g_bank
    tpbf_ram #(
      .WIDTH(8),
      .DEPTH(tpbf_pkg::FRAME_BYTES)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   (accept && in_range),
      .we_i   (write_slot == tpbf_pkg::SLOT_W'(b)),
      .addr_i (pos_q[tpbf_pkg::ADDR_W-1:0]),
      .wdata_i(pix_i.pixel_byte),
      .rdata_o(bank_rdata[b])
    );
  end

  always_comb begin
    pos_d    = pos_q;
    count_d  = count_q;
    newest_d = newest_q;
    if (accept) begin
      if (in_range) begin
        pos_d = pos_q + 1'b1;
      end
      if (pix_i.frame_end) begin
        pos_d    = '0;
        count_d  = next_count;
        newest_d = write_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      count_q    <= '0;
      newest_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      count_q    <= count_d;
      newest_q   <= newest_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q     <= pix_i.pixel_byte;
      s1_last_q   <= pix_i.frame_end;
      s1_past_q   <= past;
      s1_newest_q <= newest_q;
      s1_bypass_q <= !cfg_i.enabled || !in_range;
      s1_mode_q   <= cfg_i.mode;
    end
  end

  // Gather the newest past frames, newest first, behind the current byte.
  always_comb begin
    int slot;
    slot = 0;
    entry_o.vals[0] = s1_px_q;
    for (int i = 0; i < tpbf_pkg::RING_SLOTS; i++) begin
      slot = (int'(s1_newest_q) >= i) ? int'(s1_newest_q) - i
                                      : int'(s1_newest_q) + tpbf_pkg::RING_SLOTS - i;
      entry_o.vals[i+1] = (i < int'(s1_past_q)) ? bank_rdata[tpbf_pkg::SLOT_W'(slot)] : 8'hFF;
    end
    entry_o.count  = s1_past_q + 1'b1;
    entry_o.mode   = s1_mode_q;
    entry_o.bypass = s1_bypass_q;
    entry_o.last   = s1_last_q;
  end

  assign push_o = s1_valid_q;

endmodule

// File: sv/tpbf_queue.sv
// Short queue between front and back of the temporal pixel blend filter.
// Uses tpbf_pkg for the entry type and depth.
module tpbf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  tpbf_pkg::blend_entry_t      entry_i,
  input  logic                        pop_i,
  output tpbf_pkg::blend_entry_t      entry_o,
  output logic [tpbf_pkg::QLVL_W-1:0] level_o
);

  tpbf_pkg::blend_entry_t          slots_q [tpbf_pkg::Q_DEPTH];
  logic [tpbf_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [tpbf_pkg::QLVL_W-1:0]     level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      level_q <= level_q + tpbf_pkg::QLVL_W'(push_i) - tpbf_pkg::QLVL_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  assign entry_o = slots_q[rd_q];
  assign level_o = level_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q < tpbf_pkg::QLVL_W'(tpbf_pkg::Q_DEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (level_q != '0))
    else $error("queue pop while empty");
  a_level_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (level_q == $past(level_q) + 1'b1))
    else $error("queue level lost a push");

endmodule

// File: sv/tpbf_back.sv
// Back of the temporal pixel blend filter: sorts, then picks or (mean) sums and
// divides, one entry at a time, and holds the result on blend_o. Uses tpbf_pkg.
module tpbf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  tpbf_pkg::blend_entry_t entry_i,
  output logic                   pop_o,
  tpbf_blend_if.source           blend_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SORT = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_HOLD = 5'b10000
  } back_state_e;

  back_state_e                     state_q, state_d;
  logic [tpbf_pkg::MAX_FRAMES-1:0][7:0] s_q, s_d, s_pass;
  logic [tpbf_pkg::N_W-1:0]        n_q, n_d;
  tpbf_pkg::blend_mode_e           mode_q, mode_d;
  logic                            last_q, last_d;
  logic [tpbf_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [tpbf_pkg::N_W-1:0]        rem_q, rem_d;
  logic [7:0]                      quo_q, quo_d;
  logic [tpbf_pkg::STEP_W-1:0]     step_q, step_d;
  logic [7:0]                      res_q, res_d;

  logic [tpbf_pkg::N_W:0]          shifted;
  logic                            ge;
  logic [tpbf_pkg::N_W-1:0]        half;
  logic [8:0]                      mid_sum;
  logic [7:0]                      pick;

  // One odd-even transposition pass; step parity selects the pairing.
  always_comb begin
    s_pass = s_q;
    for (int i = 0; i + 1 < tpbf_pkg::MAX_FRAMES; i++) begin
      if ((i & 1) == int'(step_q[0])) begin
        if (s_q[i] > s_q[i+1]) begin
          s_pass[i]   = s_q[i+1];
          s_pass[i+1] = s_q[i];
        end
      end
    end
  end

  always_comb begin
    half    = n_q >> 1;
    mid_sum = {1'b0, s_q[tpbf_pkg::IDX_W'(half - 1'b1)]} + {1'b0, s_q[tpbf_pkg::IDX_W'(half)]};
    case (mode_q)
      tpbf_pkg::MODE_MEDIAN: pick = n_q[0] ? s_q[tpbf_pkg::IDX_W'(half)] : mid_sum[8:1];
      tpbf_pkg::MODE_MAX:    pick = s_q[tpbf_pkg::IDX_W'(n_q - 1'b1)];
      tpbf_pkg::MODE_MIN:    pick = s_q[0];
      default:               pick = s_q[0];
    endcase
    shifted = {rem_q, sum_q[tpbf_pkg::SUM_W-1]};
    ge      = shifted >= {1'b0, n_q};
  end

  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    n_d     = n_q;
    mode_d  = mode_q;
    last_d  = last_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          s_d    = entry_i.vals;
          n_d    = entry_i.count;
          mode_d = entry_i.mode;
          last_d = entry_i.last;
          step_d = '0;
          if (entry_i.bypass) begin
            res_d   = entry_i.vals[0];
            state_d = ST_HOLD;
          end else begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (step_q == tpbf_pkg::STEP_W'(tpbf_pkg::MAX_FRAMES)) begin
          step_d = '0;
          if (mode_q == tpbf_pkg::MODE_MEAN) begin
            sum_d   = '0;
            state_d = ST_SUM;
          end else begin
            res_d   = pick;
            state_d = ST_HOLD;
          end
        end else begin
          s_d    = s_pass;
          step_d = step_q + 1'b1;
        end
      end
      ST_SUM: begin
        if (step_q < tpbf_pkg::STEP_W'(n_q)) begin
          sum_d = sum_q + tpbf_pkg::SUM_W'(s_q[step_q[tpbf_pkg::IDX_W-1:0]]);
        end
        if (step_q == tpbf_pkg::STEP_W'(tpbf_pkg::MAX_FRAMES - 1)) begin
          rem_d   = '0;
          quo_d   = '0;
          step_d  = tpbf_pkg::STEP_W'(tpbf_pkg::SUM_W - 1);
          state_d = ST_DIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d = ge ? tpbf_pkg::N_W'(shifted - {1'b0, n_q}) : tpbf_pkg::N_W'(shifted);
        quo_d = {quo_q[6:0], ge};
        sum_d = sum_q << 1;
        if (step_q == '0) begin
          res_d   = quo_d;
          state_d = ST_HOLD;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_HOLD: begin
        if (blend_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    n_q    <= n_d;
    mode_q <= mode_d;
    last_q <= last_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  assign blend_o.valid         = (state_q == ST_HOLD);
  assign blend_o.blended_byte  = res_q;
  assign blend_o.frame_end_out = last_q;

endmodule

// File: sv/temporal_pixel_blend_filter.sv
// Top level of the temporal pixel blend filter.
// Uses tpbf_pkg, the three channel interfaces, tpbf_front, tpbf_queue, tpbf_back.
//
// Usage: bytes of a frame arrive in raster order on pix_i, one per beat,
// frame_end on the last byte. Each beat on pix_i gives exactly one beat on
// blend_o carrying the mean, median, maximum or minimum of the byte and the
// co-located bytes of up to frame_length-1 stored past frames. cfg_i writes
// frame_length, blend_mode and filter_enabled; it is always ready. The user
// must write it only while the block is idle; the block does not enforce it.
// From the input beat to the output beat, a passed-through byte goes straight
// to the back's hold state; median, maximum and minimum first run an odd-even
// sort of MAX_FRAMES lanes, and the mean adds a serial sum and bit-serial
// divide. The back works on one byte at a time and takes no new byte until
// blend_o has taken the last result.
// The front keeps accepting into a four-entry queue while the back works or
// blend_o stalls; pix_i.ready drops once the queue and the read stage
// together hold four bytes.
// Reset clears frame position, frame count and newest slot and loads
// frame_length 3, mean, enabled. History is not cleared: it is written
// before it is read in normal use, so the block is ready right after reset.
module temporal_pixel_blend_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  tpbf_pixel_if.sink   pix_i,
  tpbf_blend_if.source blend_o,
  tpbf_cfg_if.sink     cfg_i
);

  tpbf_pkg::cfg_t                cfg_q, cfg_d;
  logic                          push;
  logic                          pop;
  tpbf_pkg::blend_entry_t        push_entry;
  tpbf_pkg::blend_entry_t        head_entry;
  logic [tpbf_pkg::QLVL_W-1:0]   q_level;

  // Configuration registers: always take the beat, drop unknown indexes.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tpbf_pkg::REG_FRAME_LENGTH:   cfg_d.frame_length = cfg_i.data[tpbf_pkg::FLEN_W-1:0];
        tpbf_pkg::REG_BLEND_MODE:     cfg_d.mode = tpbf_pkg::blend_mode_e'(
                                        cfg_i.data[tpbf_pkg::MODE_W-1:0]);
        tpbf_pkg::REG_FILTER_ENABLED: cfg_d.enabled = cfg_i.data[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length <= tpbf_pkg::FLEN_W'(3);
      cfg_q.mode         <= tpbf_pkg::MODE_MEAN;
      cfg_q.enabled      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: frame state and banked history; one byte per cycle unless held off.
  tpbf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_q),
    .q_level_i(q_level),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // Queue: decouple the history read from the slower combine.
  tpbf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .entry_o(head_entry),
    .level_o(q_level)
  );

  // Back: combine one entry and hold the result until blend_o takes it.
  tpbf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_level != '0),
    .entry_i  (head_entry),
    .pop_o    (pop),
    .blend_o  (blend_o)
  );

endmodule

// File: bench/tpbf_tb_if.sv
`timescale 1ns / 1ps
// Bench-side note: the channel interfaces come from the RTL sources.
// This file holds a small bench package of stimulus row types; depends on tpbf_pkg.
package tpbf_tb_pkg;
  import tpbf_pkg::*;

  typedef struct {
    bit        is_cfg;
    cfg_reg_e  reg_idx;
    bit [3:0]  reg_data;
    bit [7:0]  px;
    bit        last;
    bit        has_known;
    bit [7:0]  known_byte;
  } stim_row_t;
endpackage

// File: bench/temporal_pixel_blend_filter_test.sv
`timescale 1ns / 1ps
// Testbench for temporal_pixel_blend_filter: a directed table then random frames,
// each output beat checked against an in-bench history/blend predictor.
// Depends on tpbf_pkg, tpbf_tb_pkg and the three channel interfaces.
module temporal_pixel_blend_filter_test;
  import tpbf_pkg::*;
  import tpbf_tb_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 60;

  logic clk_i;
  logic rst_ni;

  tpbf_pixel_if pix ();
  tpbf_blend_if blend ();
  tpbf_cfg_if   cfg ();

  temporal_pixel_blend_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix.sink),
    .blend_o (blend.source),
    .cfg_i   (cfg.sink)
  );

  // Predictor state: a shadow of the frame ring and the counters around it.
  bit [7:0] hist_mem [RING_SLOTS][FRAME_BYTES];
  int unsigned pos_cnt, frames_kept, newest;
  bit [3:0]    flen_reg;
  blend_mode_e mode_reg;
  bit          enable_reg;
  // Length of each stored frame per slot, so random frames never read unwritten bytes.
  int unsigned slot_len [RING_SLOTS];

  typedef struct { bit [7:0] b; bit last; bit has_known; bit [7:0] known; } blend_exp_t;
  blend_exp_t pending_blends [$];

  int errors = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len();
    int unsigned n;
    n = flen_reg;
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  // Number of past frames the next byte will be combined with.
  function automatic int unsigned past_used();
    int unsigned p;
    p = frames_kept;
    if (p > eff_len() - 1) p = eff_len() - 1;
    if (p > RING_SLOTS) p = RING_SLOTS;
    return p;
  endfunction

  // Shortest stored frame among those the current frame will read.
  function automatic int unsigned safe_frame_len();
    int unsigned m, s, i;
    m = FRAME_BYTES;
    for (i = 0; i < past_used(); i++) begin
      s = (newest + RING_SLOTS - i) % RING_SLOTS;
      if (slot_len[s] < m) m = slot_len[s];
    end
    return m;
  endfunction

  function automatic bit [7:0] blend_values(bit [7:0] v [MAX_FRAMES], int unsigned n,
                                            blend_mode_e m);
    int unsigned sum, i, j;
    bit [7:0] r, k;
    case (m)
      MODE_MEAN: begin
        sum = 0;
        for (i = 0; i < n; i++) sum += v[i];
        r = 8'(sum / n);
      end
      MODE_MAX: begin
        r = 0;
        for (i = 0; i < n; i++) if (v[i] > r) r = v[i];
      end
      MODE_MIN: begin
        r = 8'hff;
        for (i = 0; i < n; i++) if (v[i] < r) r = v[i];
      end
      default: begin
        for (i = 1; i < n; i++) begin
          k = v[i];
          j = i;
          while (j > 0 && v[j-1] > k) begin
            v[j] = v[j-1];
            j--;
          end
          v[j] = k;
        end
        if (n % 2 == 0) r = 8'((9'(v[n/2-1]) + 9'(v[n/2])) >> 1);
        else r = v[n/2];
      end
    endcase
    return r;
  endfunction

  // Advance the shadow ring by one pixel beat and return the expected byte.
  function automatic bit [7:0] predict_blend(bit [7:0] px, bit last);
    bit [7:0] vals [MAX_FRAMES];
    int unsigned past, wslot, i, c;
    bit [7:0] r;
    past = past_used();
    wslot = (newest + 1) % RING_SLOTS;
    r = px;
    if (pos_cnt < FRAME_BYTES) begin
      vals[0] = px;
      for (i = 0; i < past; i++)
        vals[i+1] = hist_mem[(newest + RING_SLOTS - i) % RING_SLOTS][pos_cnt];
      if (enable_reg) r = blend_values(vals, past + 1, mode_reg);
      hist_mem[wslot][pos_cnt] = px;
      pos_cnt++;
    end
    if (last) begin
      c = frames_kept;
      if (c > eff_len() - 1) c = eff_len() - 1;
      c++;
      if (c > RING_SLOTS) c = RING_SLOTS;
      frames_kept = c;
      slot_len[wslot] = pos_cnt;
      newest = wslot;
      pos_cnt = 0;
    end
    return r;
  endfunction

  // Watchdog: count cycles with no accepted beat on either channel.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (blend.valid && blend.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("status: fail");
      $finish;
    end
  end

  // Output checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    blend_exp_t e;
    if (rst_ni && blend.valid && blend.ready) begin
      if (pending_blends.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat byte=%0d last=%0d",
                                   blend.blended_byte, blend.frame_end_out);
      end else begin
        e = pending_blends[0];
        pending_blends.delete(0);
        if (e.has_known && e.known != e.b) begin
          errors++;
          if (errors <= 10) $display("table row disagrees: table=%0d pred=%0d",
                                     e.known, e.b);
        end
        if (blend.blended_byte !== e.b || blend.frame_end_out !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp byte=%0d last=%0d got byte=%0d last=%0d",
                     e.b, e.last, blend.blended_byte, blend.frame_end_out);
        end
      end
    end
  end

  // Sink stalls: mostly short, sometimes long, with stretches of none.
  int unsigned stall_phase;
  initial begin
    blend.ready = 0;
    stall_phase = 0;
    forever begin
      @(negedge clk_i);
      stall_phase++;
      if ((stall_phase / 400) % 3 == 2) blend.ready <= 1;
      else if ($urandom_range(0, 99) < 70) blend.ready <= 1;
      else begin
        blend.ready <= 0;
        repeat (($urandom_range(0, 19) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2))
          @(negedge clk_i);
      end
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 3);
  endfunction

  // Drive one pixel beat from the falling edge and hold it until accepted.
  // Valid stays high after the beat; a gap or drain() drops it.
  task automatic send_pixel(bit [7:0] px, bit last, bit has_known, bit [7:0] known);
    blend_exp_t e;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      pix.valid <= 0;
      repeat (g) @(negedge clk_i);
    end
    pix.valid <= 1;
    pix.pixel_byte <= px;
    pix.frame_end <= last;
    e.b = predict_blend(px, last);
    e.last = last;
    e.has_known = has_known;
    e.known = known;
    pending_blends.insert(pending_blends.size(), e);
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one register; only call this with the block idle.
  task automatic write_reg(cfg_reg_e idx, bit [3:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      REG_FRAME_LENGTH: flen_reg = val;
      REG_BLEND_MODE:   mode_reg = blend_mode_e'(val[1:0]);
      default:          enable_reg = val[0];
    endcase
    @(negedge clk_i);
    cfg.valid <= 0;
    @(negedge clk_i);
  endtask

  // Wait until every expected beat has come, then let the back settle.
  task automatic drain();
    pix.valid <= 0;
    while (pending_blends.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_frame(int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_pixel(8'($urandom_range(0, 255)), i == len - 1, 0, 0);
  endtask

  stim_row_t dir_rows [$];

  function automatic stim_row_t px_row(bit [7:0] p, bit l, bit k, bit [7:0] kb);
    stim_row_t r;
    r.is_cfg = 0; r.px = p; r.last = l; r.has_known = k; r.known_byte = kb;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e i, bit [3:0] d);
    stim_row_t r;
    r.is_cfg = 1; r.reg_idx = i; r.reg_data = d; r.has_known = 0;
    return r;
  endfunction

  initial begin
    stim_row_t row;
    int unsigned n, flen, s;
    pix.valid = 0; pix.pixel_byte = 0; pix.frame_end = 0;
    cfg.valid = 0; cfg.index = REG_FRAME_LENGTH; cfg.data = 0;
    pos_cnt = 0; frames_kept = 0; newest = 0;
    flen_reg = 3; mode_reg = MODE_MEAN; enable_reg = 1;
    foreach (slot_len[k]) slot_len[k] = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed table. Frames are 3 bytes. First frame after reset: no history,
    // so output equals input; then extremes, each mode, long and zero frame_length.
    dir_rows = '{
      px_row(8'd0, 0, 1, 8'd0), px_row(8'd255, 0, 1, 8'd255), px_row(8'd128, 1, 1, 8'd128),
      px_row(8'd255, 0, 1, 8'd127), px_row(8'd0, 0, 1, 8'd127), px_row(8'd1, 1, 0, 0),
      cfg_row(REG_BLEND_MODE, 4'(MODE_MEDIAN)),
      px_row(8'd255, 0, 0, 0), px_row(8'd7, 0, 0, 0), px_row(8'd129, 1, 0, 0),
      cfg_row(REG_BLEND_MODE, 4'(MODE_MAX)),
      px_row(8'd3, 0, 1, 8'd255), px_row(8'd0, 0, 0, 0), px_row(8'd0, 1, 0, 0),
      cfg_row(REG_BLEND_MODE, 4'(MODE_MIN)),
      px_row(8'd200, 0, 1, 8'd3), px_row(8'd255, 0, 1, 8'd0), px_row(8'd1, 1, 1, 8'd0),
      cfg_row(REG_FRAME_LENGTH, 4'd15), cfg_row(REG_FILTER_ENABLED, 4'd0),
      px_row(8'd42, 0, 1, 8'd42), px_row(8'd17, 0, 1, 8'd17), px_row(8'd99, 1, 1, 8'd99),
      cfg_row(REG_FRAME_LENGTH, 4'd0), cfg_row(REG_FILTER_ENABLED, 4'd1),
      px_row(8'd5, 0, 1, 8'd5), px_row(8'd6, 0, 1, 8'd6), px_row(8'd250, 1, 1, 8'd250)
    };
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_idx, row.reg_data);
      end else send_pixel(row.px, row.last, row.has_known, row.known_byte);
    end

    // Random phases: new settings, then a run of frames whose length never
    // exceeds the shortest stored frame that will be read.
    n = 0;
    while (n < 1800) begin
      drain();
      s = $urandom_range(0, 9);
      if (s < 2) flen = (s == 0) ? 10 : 1;
      else flen = $urandom_range(0, 15);
      write_reg(REG_FRAME_LENGTH, 4'(flen));
      write_reg(REG_BLEND_MODE, 4'($urandom_range(0, 3)));
      write_reg(REG_FILTER_ENABLED, 4'($urandom_range(0, 5) != 0));
      repeat ($urandom_range(4, 14)) begin
        s = safe_frame_len();
        if (s > 24) s = 24;
        s = $urandom_range(1, s);
        send_frame(s);
        n += s;
      end
    end

    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// File: files.f
sv/tpbf_pkg.sv
sv/tpbf_pixel_if.sv
sv/tpbf_blend_if.sv
sv/tpbf_cfg_if.sv
sv/tpbf_ram.sv
sv/tpbf_front.sv
sv/tpbf_queue.sv
sv/tpbf_back.sv
sv/temporal_pixel_blend_filter.sv
bench/tpbf_tb_if.sv
bench/temporal_pixel_blend_filter_test.sv
